// ----- hw/rtl/rpe_pkg.sv -----
// Shared types, constants and packet-building functions of the run-length encoder.
`timescale 1ns / 1ps

package rpe_pkg;

   localparam int MAX_BLOCK_BYTES = 8192;

   localparam int OFF_W  = 14;
   localparam int SEEN_W = $clog2(MAX_BLOCK_BYTES + 2);
   localparam int CNT_W  = 7;

   localparam logic [OFF_W-1:0]  OFF_MAX    = {OFF_W{1'b1}};
   localparam logic [SEEN_W-1:0] SEEN_LIMIT = SEEN_W'(MAX_BLOCK_BYTES);
   localparam logic [SEEN_W-1:0] SEEN_OVER  = SEEN_W'(MAX_BLOCK_BYTES + 1);
   localparam logic [CNT_W-1:0]  LIT_MAX    = 7'h7F;
   localparam logic              RUN_FLAG   = 1'b1;   // top bit of a repeat header (0x80)

   // command queue between the classifier and the write sequencer
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

   // index of the last write in a command: one packet action or two
   localparam logic [1:0] WR_LAST_ONE = 2'd1;
   localparam logic [1:0] WR_LAST_TWO = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_block;
   } req_word_type;

   typedef struct packed {
      logic [OFF_W-1:0] write_offset;
      logic [7:0]       write_byte;
      logic             item_done;
      logic             block_done;
      logic [OFF_W-1:0] compressed_length;
      logic             overflow;
   } rsp_word_type;

   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic [7:0]       value;
   } write_type;

   // every packet action is exactly two buffer writes
   typedef struct packed {
      write_type first;
      write_type second;
   } action_type;

   typedef struct packed {
      action_type       act;
      logic [OFF_W-1:0] hdr;
      logic [OFF_W-1:0] nxt;
      logic [CNT_W-1:0] cnt;
   } step_type;

   typedef struct packed {
      action_type       act0;
      action_type       act1;
      logic             two_act;
      logic             eob;
      logic             ovf;
      logic [OFF_W-1:0] length;
   } cmd_type;

   // saturating offset advance
   function automatic logic [OFF_W-1:0] off_add(input logic [OFF_W-1:0] x,
                                                input logic [1:0] k);
      logic [OFF_W:0] sum;
      sum = {1'b0, x} + (OFF_W + 1)'(k);
      return (sum > {1'b0, OFF_MAX}) ? OFF_MAX : sum[OFF_W-1:0];
   endfunction

   // close a repeat packet: header then value
   function automatic step_type run_action(input logic [OFF_W-1:0] o,
                                           input logic [OFF_W-1:0] hdr,
                                           input logic [CNT_W-1:0] cnt,
                                           input logic [7:0] pend);
      step_type s;
      s.act.first  = '{offset: o, value: {RUN_FLAG, cnt}};
      s.act.second = '{offset: off_add(o, 2'd1), value: pend};
      s.hdr        = hdr;
      s.nxt        = off_add(o, 2'd2);
      s.cnt        = cnt;
      return s;
   endfunction

   // append one literal byte, opening a new packet when none is open or it is full
   function automatic step_type lit_action(input logic [OFF_W-1:0] o,
                                           input logic [OFF_W-1:0] hdr,
                                           input logic [CNT_W-1:0] cnt,
                                           input logic [7:0] pend);
      step_type         s;
      logic [CNT_W-1:0] c;
      logic [OFF_W-1:0] h;
      logic [OFF_W-1:0] d;
      c = (cnt == LIT_MAX) ? '0 : cnt;
      if (c == '0) begin
         h     = o;
         d     = off_add(o, 2'd1);
         s.nxt = off_add(o, 2'd2);
      end else begin
         h     = hdr;
         d     = o;
         s.nxt = off_add(o, 2'd1);
      end
      s.cnt        = c + 7'd1;
      s.hdr        = h;
      s.act.first  = '{offset: d, value: pend};
      s.act.second = '{offset: h, value: {1'b0, s.cnt}};
      return s;
   endfunction

endpackage

// ----- hw/rtl/rpe_front.sv -----
// Classifier: holds the packet state, takes one byte a cycle unless req_full, issues write commands.
`timescale 1ns / 1ps

module rpe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  rpe_pkg::req_word_type req_word,
   output logic                  req_full,
   output logic                  cmd_push,
   output rpe_pkg::cmd_type      cmd_word,
   input  logic                  cmd_full
);
   import rpe_pkg::*;

   logic [7:0]        pend_ff, pend_in;
   logic              have_ff, have_in;
   logic              rep_ff, rep_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [OFF_W-1:0]  hdr_ff, hdr_in;
   logic [OFF_W-1:0]  nxt_ff, nxt_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;

   // state after the byte itself, before any flush
   logic [7:0]        pend1;
   logic              have1, rep1;
   logic [CNT_W-1:0]  cnt1;
   logic [OFF_W-1:0]  hdr1, nxt1;
   logic [SEEN_W-1:0] seen1;

   logic     accept, take, flush, main_run, main_lit, has_main;
   step_type run0, lit0, run1, lit1, flush_step;
   action_type main_act;

   assign accept   = req_push && !cmd_full;
   assign req_full = cmd_full;
   assign take     = seen_ff < SEEN_LIMIT;

   assign run0 = run_action(nxt_ff, hdr_ff, cnt_ff, pend_ff);
   assign lit0 = lit_action(nxt_ff, hdr_ff, cnt_ff, pend_ff);

   always_comb begin
      have1    = have_ff;
      rep1     = rep_ff;
      cnt1     = cnt_ff;
      pend1    = pend_ff;
      hdr1     = hdr_ff;
      nxt1     = nxt_ff;
      seen1    = SEEN_OVER;
      main_run = 1'b0;
      main_lit = 1'b0;
      if (take) begin
         seen1 = seen_ff + 1'b1;
         priority if (!have_ff) begin
            pend1 = req_word.data_byte;
            have1 = 1'b1;
            rep1  = 1'b0;
            cnt1  = '0;
         end else if (rep_ff) begin
            priority if (cnt_ff == LIT_MAX) begin
               // full run: close it, new byte starts a run of one
               main_run = 1'b1;
               pend1    = req_word.data_byte;
               cnt1     = '0;
               nxt1     = run0.nxt;
            end else if (req_word.data_byte == pend_ff) begin
               cnt1 = cnt_ff + 7'd1;
            end else begin
               main_run = 1'b1;
               rep1     = 1'b0;
               cnt1     = '0;
               pend1    = req_word.data_byte;
               nxt1     = run0.nxt;
            end
         end else if (req_word.data_byte == pend_ff) begin
            rep1 = 1'b1;
            cnt1 = 7'd1;
         end else begin
            main_lit = 1'b1;
            hdr1     = lit0.hdr;
            nxt1     = lit0.nxt;
            cnt1     = lit0.cnt;
            pend1    = req_word.data_byte;
         end
      end
   end

   assign run1       = run_action(nxt1, hdr1, cnt1, pend1);
   assign lit1       = lit_action(nxt1, hdr1, cnt1, pend1);
   assign flush_step = rep1 ? run1 : lit1;
   assign flush      = req_word.end_of_block && have1;
   assign has_main   = main_run || main_lit;
   assign main_act   = main_run ? run0.act : lit0.act;

   always_comb begin
      cmd_word.act0    = has_main ? main_act : flush_step.act;
      cmd_word.act1    = flush_step.act;
      cmd_word.two_act = has_main && flush;
      cmd_word.eob     = req_word.end_of_block;
      cmd_word.ovf     = seen1 > SEEN_LIMIT;
      cmd_word.length  = flush ? flush_step.nxt : nxt1;
   end

   assign cmd_push = accept && (has_main || flush);

   always_comb begin
      pend_in = pend_ff;
      have_in = have_ff;
      rep_in  = rep_ff;
      cnt_in  = cnt_ff;
      hdr_in  = hdr_ff;
      nxt_in  = nxt_ff;
      seen_in = seen_ff;
      if (accept) begin
         if (req_word.end_of_block) begin
            pend_in = '0;
            have_in = 1'b0;
            rep_in  = 1'b0;
            cnt_in  = '0;
            hdr_in  = '0;
            nxt_in  = '0;
            seen_in = '0;
         end else begin
            pend_in = pend1;
            have_in = have1;
            rep_in  = rep1;
            cnt_in  = cnt1;
            hdr_in  = hdr1;
            nxt_in  = nxt1;
            seen_in = seen1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         have_ff <= 1'b0;
         rep_ff  <= 1'b0;
         cnt_ff  <= '0;
         hdr_ff  <= '0;
         nxt_ff  <= '0;
         seen_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         have_ff <= have_in;
         rep_ff  <= rep_in;
         cnt_ff  <= cnt_in;
         hdr_ff  <= hdr_in;
         nxt_ff  <= nxt_in;
         seen_ff <= seen_in;
      end
   end

endmodule

// ----- hw/rtl/rpe_cmd_queue.sv -----
// Short command queue between the classifier and the write sequencer.
`timescale 1ns / 1ps

module rpe_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rpe_pkg::cmd_type push_word,
   output logic             full,
   input  logic             pop,
   output rpe_pkg::cmd_type pop_word,
   output logic             empty
);
   import rpe_pkg::*;

   cmd_type            slot_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CW-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = count_ff == CMDQ_CW'(CMDQ_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? CMDQ_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? CMDQ_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/rpe_back.sv -----
// Write sequencer: expands each command into buffer writes, one per cycle while the result register drains.
`timescale 1ns / 1ps

module rpe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   input  rpe_pkg::cmd_type      cmd_word,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rpe_pkg::rsp_word_type rsp_word
);
   import rpe_pkg::*;

   logic [1:0]   idx_ff, idx_in;
   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;
   logic         load, is_last;
   logic [1:0]   last_idx;
   action_type   act;
   write_type    wr;

   assign last_idx = cmd_word.two_act ? WR_LAST_TWO : WR_LAST_ONE;
   assign is_last  = idx_ff == last_idx;
   assign load     = !cmd_empty && (!valid_ff || rsp_pop);
   assign cmd_pop  = load && is_last;
   assign act      = idx_ff[1] ? cmd_word.act1 : cmd_word.act0;
   assign wr       = idx_ff[0] ? act.second : act.first;

   always_comb begin
      word_in.write_offset      = wr.offset;
      word_in.write_byte        = wr.value;
      word_in.item_done         = is_last;
      word_in.block_done        = is_last && cmd_word.eob;
      word_in.compressed_length = (is_last && cmd_word.eob) ? cmd_word.length : '0;
      word_in.overflow          = cmd_word.ovf;
      idx_in   = load ? (is_last ? 2'd0 : idx_ff + 2'd1) : idx_ff;
      valid_in = load || (valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ----- hw/rtl/rle_packet_encoder_core.sv -----
// Top level of the PackBits-style run-length encoder core.
`timescale 1ns / 1ps

// Run-length encoder that turns a byte stream into buffer writes (offset, byte).
// Bytes enter one word per push; end_of_block on a byte flushes the open packet,
// marks the final write with block_done and compressed_length, and starts a new
// block at offset 0. Repeat packets are header 0x80|(n-1) plus value (n up to 128);
// literal packets are header L (up to 127) plus L bytes, and the header is written
// again after every literal byte. Bytes past MAX_BLOCK_BYTES are dropped and the
// block's later writes carry overflow.
// Rate: the classifier takes one byte per cycle as long as the four-entry command
// queue has room; the write sequencer drives one write per cycle through the single
// result register while the receiver pops it. A byte causes no write when it
// extends a run, two for a literal byte or a closed run, up to four with a flush.
// Sustained literal data is therefore limited by the one write port. A pushed byte
// reaches the result ports through the command queue and the result register.

module rle_packet_encoder_core (
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_push,
   input  rpe_pkg::req_word_type req_word,
   output logic                  req_full,
   // buffer write output
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rpe_pkg::rsp_word_type rsp_word
);
   import rpe_pkg::*;

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_in_word, cmd_out_word;

   // front: packet state and byte classification
   rpe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_word (cmd_in_word),
      .cmd_full (cmd_full)
   );

   // decouples classification from the write port
   rpe_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_word (cmd_in_word),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_word  (cmd_out_word),
      .empty     (cmd_empty)
   );

   // back: one buffer write per cycle into the result register while it is popped
   rpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_word  (cmd_out_word),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   // nothing survives a reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (cmd_empty && rsp_empty))
      else $error("queue or result register not empty after reset");

   // queue occupancy is consistent
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(cmd_full && cmd_empty))
      else $error("command queue both full and empty");

   // a block ends only on the last write of its byte
   a_block_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.block_done) |-> rsp_word.item_done)
      else $error("block_done without item_done");

   // length is shown only with block_done
   a_length_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_word.block_done) |-> (rsp_word.compressed_length == '0))
      else $error("compressed_length nonzero before end of block");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the run-length packet encoder core.
`timescale 1ns / 1ps

// Test plan:
//  - A short table of directed words: single-byte blocks, 0x00/0xFF data,
//    silent steps, run and literal packets, a full run of 128, a full
//    literal of 127 (mid-block and at the end flush), wrap of ramp data.
//    Most short rows carry hand-worked buffer writes; the rest use the predictor.
//  - Random blocks built from runs, literal stretches, long runs/literals
//    near the packet limits, and 0x00/0xFF noise.
//  - Sender works in bursts with random gaps; receiver pops on changing
//    patterns, holds off for a long stretch once so the core back-pressures.
module tb;

   import rpe_pkg::*;

   localparam int PREDICTED   = -1;       // row has no hand-worked writes
   localparam int HOLD_CYCLES = 300;      // long receiver hold-off
   localparam int RAND_WORDS  = 40;
   localparam int TAIL_CYCLES = 16;       // latency slack after the last write
   localparam int DRAIN_LIMIT = 200000;

   typedef enum int {SEG_RUN, SEG_LIT, SEG_LONG_RUN, SEG_LONG_LIT, SEG_NOISE} seg_kind_type;
   typedef enum int {RX_ALWAYS, RX_COIN, RX_ONE_IN_FOUR, RX_MOSTLY} rx_mode_type;

   typedef struct {
      logic [7:0]       value;
      logic             ramp;     // 1: byte steps by one per repeat
      int               reps;
      logic             eob;      // end_of_block on the last repeat
      int               n_wr;     // hand-worked writes, or PREDICTED
      logic [OFF_W-1:0] off0;
      logic [7:0]       byte0;
      logic [OFF_W-1:0] off1;
      logic [7:0]       byte1;
      logic [OFF_W-1:0] length;
   } stim_row_type;

   // ---------------------------------------------------------------- clock / DUT
   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         req_push = 1'b0;
   req_word_type req_word = '0;
   logic         req_full;
   logic         rsp_empty;
   logic         rsp_pop  = 1'b0;
   rsp_word_type rsp_word;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rle_packet_encoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   // ---------------------------------------------------------------- encoder state
   // Mirror of the encoder: pending byte, packet kind and count, offsets.
   logic [7:0]       held_byte;
   logic             held_valid;
   logic             in_run;       // 1: open packet is a repeat run
   logic [CNT_W-1:0] pkt_len;      // literal: bytes in packet; run: length - 1
   logic [OFF_W-1:0] hdr_at;       // header of the open literal packet
   logic [OFF_W-1:0] wr_at;        // next free buffer byte
   int               block_seen;   // bytes taken in this block, MAX+1 once over

   rsp_word_type step_wr[$];       // writes caused by the current word
   rsp_word_type typed_wr[$];      // hand-worked writes of a table row
   rsp_word_type writes_due[$];    // buffer writes still to come out
   logic         use_typed = 1'b0;

   int errors         = 0;
   int writes_checked = 0;
   int words_sent     = 0;
   int blocks_sent    = 0;
   int burst_left     = 0;
   int hold_requests  = 0;

   function automatic logic [OFF_W-1:0] off_next(input logic [OFF_W-1:0] x);
      return (x == OFF_MAX) ? x : x + 1'b1;
   endfunction

   function automatic rsp_word_type buf_write(input logic [OFF_W-1:0] o, input logic [7:0] v);
      rsp_word_type w;
      w              = '0;
      w.write_offset = o;
      w.write_byte   = v;
      return w;
   endfunction

   task automatic clear_block();
      held_byte  = '0;
      held_valid = 1'b0;
      in_run     = 1'b0;
      pkt_len    = '0;
      hdr_at     = '0;
      wr_at      = '0;
      block_seen = 0;
   endtask

   // repeat packet: 0x80|(n-1), then the value
   task automatic emit_run();
      step_wr.push_back(buf_write(wr_at, {1'b1, pkt_len}));
      wr_at = off_next(wr_at);
      step_wr.push_back(buf_write(wr_at, held_byte));
      wr_at = off_next(wr_at);
   endtask

   // literal byte, then header rewrite; a full packet of 127 opens a new one
   task automatic emit_literal();
      if (pkt_len == LIT_MAX)
         pkt_len = '0;
      if (pkt_len == '0) begin
         hdr_at = wr_at;
         wr_at  = off_next(wr_at);
      end
      step_wr.push_back(buf_write(wr_at, held_byte));
      wr_at   = off_next(wr_at);
      pkt_len = pkt_len + 1'b1;
      step_wr.push_back(buf_write(hdr_at, {1'b0, pkt_len}));
   endtask

   // Advance the encoder by one word; leaves its writes in step_wr.
   task automatic encode_word(input req_word_type w);
      logic ovf;
      step_wr.delete();
      if (block_seen < MAX_BLOCK_BYTES) begin
         block_seen++;
         if (!held_valid) begin
            held_byte  = w.data_byte;
            held_valid = 1'b1;
            in_run     = 1'b0;
            pkt_len    = '0;
         end else if (in_run) begin
            if (pkt_len == LIT_MAX) begin
               // run of 128 closes; new byte starts a run of one
               emit_run();
               held_byte = w.data_byte;
               pkt_len   = '0;
            end else if (w.data_byte == held_byte) begin
               pkt_len = pkt_len + 1'b1;
            end else begin
               emit_run();
               in_run    = 1'b0;
               pkt_len   = '0;
               held_byte = w.data_byte;
            end
         end else if (w.data_byte == held_byte) begin
            in_run  = 1'b1;
            pkt_len = 7'd1;
         end else begin
            emit_literal();
            held_byte = w.data_byte;
         end
      end else begin
         block_seen = MAX_BLOCK_BYTES + 1;   // dropped byte
      end

      if (w.end_of_block && held_valid) begin
         if (in_run)
            emit_run();
         else
            emit_literal();
      end

      ovf = (block_seen > MAX_BLOCK_BYTES);
      foreach (step_wr[k])
         step_wr[k].overflow = ovf;
      if (step_wr.size() > 0) begin
         step_wr[$].item_done = 1'b1;
         if (w.end_of_block) begin
            step_wr[$].block_done        = 1'b1;
            step_wr[$].compressed_length = wr_at;
         end
      end
      if (w.end_of_block)
         clear_block();
   endtask

   // ---------------------------------------------------------------- sender
   // Bursts of random length; gaps of random length between them.
   task automatic send_word(input logic [7:0] b, input logic eob);
      req_word_type w;
      int           gap;
      w.data_byte    = b;
      w.end_of_block = eob;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_push <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_full);
      // word taken at this edge
      words_sent++;
      if (eob)
         blocks_sent++;
      encode_word(w);
      if (use_typed) begin
         foreach (typed_wr[k])
            writes_due.push_back(typed_wr[k]);
         use_typed = 1'b0;
      end else begin
         foreach (step_wr[k])
            writes_due.push_back(step_wr[k]);
      end
   endtask

   // sender goes quiet until every due write has come out
   task automatic drain_writes();
      int guard;
      guard = 0;
      req_push <= 1'b0;
      while (writes_due.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // ---------------------------------------------------------------- receiver
   rx_mode_type rx_mode      = RX_ALWAYS;
   int          rx_mode_left = 0;
   int          rx_tick      = 0;
   int          hold_left    = 0;
   int          holds_served = 0;

   task automatic check_write(input rsp_word_type got);
      rsp_word_type want;
      logic         bad;
      if (writes_due.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: unexpected write off=%0d byte=%02h", $realtime,
                     got.write_offset, got.write_byte);
         return;
      end
      want = writes_due.pop_front();
      writes_checked++;
      bad = (got.write_offset      !== want.write_offset)      ||
            (got.write_byte        !== want.write_byte)        ||
            (got.item_done         !== want.item_done)         ||
            (got.block_done        !== want.block_done)        ||
            (got.compressed_length !== want.compressed_length) ||
            (got.overflow          !== want.overflow);
      if (bad) begin
         errors++;
         if (errors <= 10)
            $display("%0t: write mismatch exp off=%0d byte=%02h id=%b bd=%b len=%0d ovf=%b",
                     $realtime, want.write_offset, want.write_byte, want.item_done,
                     want.block_done, want.compressed_length, want.overflow,
                     "\n      got off=%0d byte=%02h id=%b bd=%b len=%0d ovf=%b",
                     got.write_offset, got.write_byte, got.item_done,
                     got.block_done, got.compressed_length, got.overflow);
      end
   endtask

   // Pops on a pattern that is redrawn at random intervals; a hold request
   // from the stimulus blocks pops for HOLD_CYCLES, counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            check_write(rsp_word);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 120);
         end else begin
            rx_mode_left--;
         end
         rx_tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS:      rsp_pop <= 1'b1;
               RX_COIN:        rsp_pop <= 1'($urandom_range(0, 1));
               RX_ONE_IN_FOUR: rsp_pop <= (rx_tick % 4 == 0);
               default:        rsp_pop <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- directed table
   stim_row_type dir_rows[$];

   function automatic stim_row_type mk_row(input logic [7:0] value, input logic ramp,
                                           input int reps, input logic eob, input int n_wr,
                                           input int off0, input logic [7:0] byte0,
                                           input int off1, input logic [7:0] byte1,
                                           input int length);
      stim_row_type r;
      r.value  = value;
      r.ramp   = ramp;
      r.reps   = reps;
      r.eob    = eob;
      r.n_wr   = n_wr;
      r.off0   = OFF_W'(off0);
      r.byte0  = byte0;
      r.off1   = OFF_W'(off1);
      r.byte1  = byte1;
      r.length = OFF_W'(length);
      return r;
   endfunction

   task automatic load_typed(input stim_row_type r);
      typed_wr.delete();
      if (r.n_wr >= 1)
         typed_wr.push_back(buf_write(r.off0, r.byte0));
      if (r.n_wr >= 2)
         typed_wr.push_back(buf_write(r.off1, r.byte1));
      if (r.n_wr >= 1) begin
         typed_wr[$].item_done = 1'b1;
         typed_wr[$].block_done = r.eob;
         typed_wr[$].compressed_length = r.eob ? r.length : '0;
      end
   endtask

   // ---------------------------------------------------------------- stimulus
   initial begin
      stim_row_type r;
      logic [7:0]   b;
      logic [7:0]   last_b;
      int           nseg;
      int           seg_len;
      int           guard;
      int           rand_start;
      seg_kind_type kind;

      clear_block();

      //                value  ramp reps eob  n_wr        off0 b0     off1 b1     len
      // single byte block: literal header at 0, byte at 1
      dir_rows.push_back(mk_row(8'h00, 0, 1,   1, 2,         1, 8'h00, 0, 8'h01, 2));
      // silent steps: first byte pending, second starts a run
      dir_rows.push_back(mk_row(8'hFF, 0, 1,   0, 0,         0, 8'h00, 0, 8'h00, 0));
      dir_rows.push_back(mk_row(8'hFF, 0, 1,   0, 0,         0, 8'h00, 0, 8'h00, 0));
      // run of two closes on a new byte
      dir_rows.push_back(mk_row(8'h00, 0, 1,   0, 2,         0, 8'h81, 1, 8'hFF, 0));
      // literal opens at 2, then grows
      dir_rows.push_back(mk_row(8'h55, 0, 1,   0, 2,         3, 8'h00, 2, 8'h01, 0));
      dir_rows.push_back(mk_row(8'hAA, 0, 1,   0, 2,         4, 8'h55, 2, 8'h02, 0));
      // repeat of the pending byte on the last word: flush as run of two
      dir_rows.push_back(mk_row(8'hAA, 0, 1,   1, 2,         5, 8'h81, 6, 8'hAA, 7));
      dir_rows.push_back(mk_row(8'h01, 0, 1,   0, 0,         0, 8'h00, 0, 8'h00, 0));
      // literal add plus flush add: four writes
      dir_rows.push_back(mk_row(8'h02, 0, 1,   1, PREDICTED, 0, 8'h00, 0, 8'h00, 0));
      // full run of 128 (header 0xFF) closed by a 129th equal byte, then flushed
      dir_rows.push_back(mk_row(8'h7F, 0, 129, 1, PREDICTED, 0, 8'h00, 0, 8'h00, 0));
      // full literal of 127 split mid-block
      dir_rows.push_back(mk_row(8'h10, 1, 130, 1, PREDICTED, 0, 8'h00, 0, 8'h00, 0));
      // full literal split by the end flush
      dir_rows.push_back(mk_row(8'h20, 1, 128, 1, PREDICTED, 0, 8'h00, 0, 8'h00, 0));
      // data wraps 0xFE, 0xFF, 0x00
      dir_rows.push_back(mk_row(8'hFE, 1, 3,   1, PREDICTED, 0, 8'h00, 0, 8'h00, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         for (int rep = 0; rep < r.reps; rep++) begin
            if (r.n_wr != PREDICTED && rep == r.reps - 1) begin
               load_typed(r);
               use_typed = 1'b1;
            end
            b = r.ramp ? r.value + 8'(rep) : r.value;
            send_word(b, r.eob && (rep == r.reps - 1));
         end
      end
      drain_writes();

      // random blocks; receiver holds off early while the sender keeps going
      hold_requests++;
      rand_start = words_sent;
      last_b     = 8'h00;
      while (words_sent - rand_start < RAND_WORDS) begin
         nseg = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 8);
         for (int s = 0; s < nseg; s++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: kind = SEG_RUN;
               4, 5, 6:    kind = SEG_LIT;
               7:          kind = SEG_LONG_RUN;
               8:          kind = SEG_LONG_LIT;
               default:    kind = SEG_NOISE;
            endcase
            case (kind)
               SEG_RUN:      seg_len = $urandom_range(1, 5);
               SEG_LIT:      seg_len = $urandom_range(1, 6);
               SEG_LONG_RUN: seg_len = $urandom_range(124, 132);
               SEG_LONG_LIT: seg_len = $urandom_range(124, 131);
               default:      seg_len = $urandom_range(1, 8);
            endcase
            b = 8'($urandom_range(0, 255));
            for (int k = 0; k < seg_len; k++) begin
               if (kind == SEG_LIT || kind == SEG_LONG_LIT) begin
                  b = 8'($urandom_range(0, 255));
                  if (b == last_b)
                     b = b ^ 8'h01;
               end else if (kind == SEG_NOISE) begin
                  b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               end
               last_b = b;
               send_word(b, (s == nseg - 1) && (k == seg_len - 1));
            end
         end
         // pause now and then until the core is empty
         if ($urandom_range(0, 9) == 0)
            drain_writes();
      end

      // wait out the remaining writes, then the TAIL_CYCLES margin for strays
      req_push <= 1'b0;
      guard = 0;
      while (writes_due.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (writes_due.size() != 0) begin
         $display("%0d buffer writes never came out", writes_due.size());
         errors += writes_due.size();
      end

      $display("Encoded %0d bytes in %0d blocks, incl. a full run and full literals",
               words_sent, blocks_sent);
      $display("split mid-block and at the flush; %0d buffer writes compared, %0d mismatches.",
               writes_checked, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hard stop: well above the slowest legal run
   initial begin
      #16_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
